@@ sv/dplc_pkg.sv @@
package dplc_pkg;

    localparam int ID_W    = 64;
    localparam int STATE_W = 8;
    localparam int OP_W    = 2;
    localparam int STAT_W  = 2;

    // one store word: id in the low bits, state byte above it
    localparam int ENTRY_W = ID_W + STATE_W;

    // opcode, doc_id, entry_state packed and rounded up to whole bytes
    localparam int IN_FIELDS_W  = OP_W + ID_W + STATE_W;
    localparam int IN_DATA_W    = ((IN_FIELDS_W + 7) / 8) * 8;
    // cur_id, cur_state, at_end, status packed and rounded up to whole bytes
    localparam int OUT_FIELDS_W = ID_W + STATE_W + 1 + STAT_W;
    localparam int OUT_DATA_W   = ((OUT_FIELDS_W + 7) / 8) * 8;

    typedef enum logic [OP_W-1:0] {
        OP_CLEAR  = 2'd0,
        OP_APPEND = 2'd1,
        OP_STEP   = 2'd2,
        OP_SKIP   = 2'd3
    } t_opcode;

    typedef enum logic [STAT_W-1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_ORDER = 2'd2
    } t_status;

endpackage

@@ sv/dplc_ram.sv @@
module dplc_ram #(
    parameter int DEPTH = 1024,
    parameter int WIDTH = 72
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

@@ sv/descending_posting_list_cursor.sv @@
// Cursor over a list of up to MAX_ENTRIES (64-bit id, 8-bit state) pairs held in descending id
// order in one single-port-read RAM; every input transfer yields exactly one result transfer
// with the entry under the cursor, an end flag and a status. One item is worked on at a time,
// and the next is taken while the previous result waits at the output. A clear goes straight
// to the emit state; append and step fetch the entry under the cursor (a RAM read, unless the
// cursor is at the end) before emitting; skip first runs a binary search of p probes, with p
// at most ceil(log2(entry_count+1)), and then fetches as step does. Each probe issues a RAM
// read in S_SEARCH and compares its data in S_CMP. Input is taken again in the same cycle as
// the result is offered. While an earlier result still waits unaccepted at the output, the
// item holds in its last state until that result is taken.
// No clearing pass is needed after reset; only entries below the fill count are ever read.
module descending_posting_list_cursor #(
    parameter int MAX_ENTRIES = 1024
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    // opcode[1:0], doc_id[65:2], entry_state[73:66], zero fill above
    input  logic [dplc_pkg::IN_DATA_W-1:0]     s_axis_tdata,
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // cur_id[63:0], cur_state[71:64], at_end[72], status[74:73], zero fill above
    output logic [dplc_pkg::OUT_DATA_W-1:0]    m_axis_tdata
);

    localparam int AW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int CW = $clog2(MAX_ENTRIES + 1);
    localparam logic [CW-1:0] MAX_CNT = CW'(MAX_ENTRIES);

    localparam int IW = dplc_pkg::ID_W;
    localparam int SW = dplc_pkg::STATE_W;

    typedef enum logic [5:0] {
        S_IDLE   = 6'b000001,
        S_FETCH  = 6'b000010,
        S_WAIT   = 6'b000100,
        S_SEARCH = 6'b001000,
        S_CMP    = 6'b010000,
        S_EMIT   = 6'b100000
    } t_state;

    t_state r_state, n_state;

    logic [CW-1:0] r_count, n_count;
    logic [CW-1:0] r_cursor, n_cursor;
    logic [CW-1:0] r_lo, n_lo;
    logic [CW-1:0] r_hi, n_hi;
    logic [CW-1:0] r_mid, n_mid;
    logic [IW-1:0] r_target, n_target;
    logic [IW-1:0] r_last_id, n_last_id;
    dplc_pkg::t_status r_status, n_status;

    logic [IW-1:0] r_res_id, n_res_id;
    logic [SW-1:0] r_res_state, n_res_state;
    logic          r_res_end, n_res_end;

    logic                          r_m_tvalid, n_m_tvalid;
    logic [dplc_pkg::OUT_DATA_W-1:0] r_m_tdata, n_m_tdata;

    logic                         w_wr_en;
    logic [AW-1:0]                w_wr_addr;
    logic [dplc_pkg::ENTRY_W-1:0] w_wr_data;
    logic                         w_rd_en;
    logic [AW-1:0]                w_rd_addr;
    logic [dplc_pkg::ENTRY_W-1:0] w_rd_data;

    dplc_pkg::t_opcode w_op;
    logic [IW-1:0]     w_in_id;
    logic [SW-1:0]     w_in_state;
    logic              w_accept;
    logic [CW:0]       w_sum;

    assign w_op       = dplc_pkg::t_opcode'(s_axis_tdata[dplc_pkg::OP_W-1:0]);
    assign w_in_id    = s_axis_tdata[dplc_pkg::OP_W +: IW];
    assign w_in_state = s_axis_tdata[dplc_pkg::OP_W + IW +: SW];
    assign w_accept   = s_axis_tvalid && s_axis_tready;
    assign w_sum      = {1'b0, r_lo} + {1'b0, r_hi};

    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = r_m_tvalid;
    assign m_axis_tdata  = r_m_tdata;

    dplc_ram #(
        .DEPTH (MAX_ENTRIES),
        .WIDTH (dplc_pkg::ENTRY_W)
    ) u_store (
        .i_clk     (i_clk),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (w_wr_addr),
        .i_wr_data (w_wr_data),
        .i_rd_en   (w_rd_en),
        .i_rd_addr (w_rd_addr),
        .o_rd_data (w_rd_data)
    );

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_cursor    = r_cursor;
        n_lo        = r_lo;
        n_hi        = r_hi;
        n_mid       = r_mid;
        n_target    = r_target;
        n_last_id   = r_last_id;
        n_status    = r_status;
        n_res_id    = r_res_id;
        n_res_state = r_res_state;
        n_res_end   = r_res_end;
        n_m_tvalid  = r_m_tvalid;
        n_m_tdata   = r_m_tdata;
        w_wr_en     = 1'b0;
        w_wr_addr   = r_count[AW-1:0];
        w_wr_data   = {w_in_state, w_in_id};
        w_rd_en     = 1'b0;
        w_rd_addr   = r_cursor[AW-1:0];

        // drop the output once the downstream side takes it
        if (r_m_tvalid && m_axis_tready) begin
            n_m_tvalid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_status = dplc_pkg::ST_OK;
                    unique case (w_op)
                        dplc_pkg::OP_CLEAR: begin
                            n_count     = '0;
                            n_cursor    = '0;
                            n_res_id    = '0;
                            n_res_state = '0;
                            n_res_end   = 1'b1;
                            n_state     = S_EMIT;
                        end
                        dplc_pkg::OP_APPEND: begin
                            if (r_count == MAX_CNT) begin
                                n_status = dplc_pkg::ST_FULL;
                            end else if (r_count != '0 && w_in_id >= r_last_id) begin
                                n_status = dplc_pkg::ST_ORDER;
                            end else begin
                                w_wr_en   = 1'b1;
                                n_count   = r_count + CW'(1);
                                n_last_id = w_in_id;
                            end
                            n_state = S_FETCH;
                        end
                        dplc_pkg::OP_STEP: begin
                            if (r_cursor < r_count) begin
                                n_cursor = r_cursor + CW'(1);
                            end
                            n_state = S_FETCH;
                        end
                        dplc_pkg::OP_SKIP: begin
                            n_lo     = '0;
                            n_hi     = r_count;
                            n_target = w_in_id;
                            n_state  = S_SEARCH;
                        end
                        default: ;
                    endcase
                end
            end
            S_FETCH: begin
                if (r_cursor < r_count) begin
                    w_rd_en = 1'b1;
                    n_state = S_WAIT;
                end else begin
                    n_res_id    = '0;
                    n_res_state = '0;
                    n_res_end   = 1'b1;
                    n_state     = S_EMIT;
                end
            end
            S_WAIT: begin
                n_res_id    = w_rd_data[IW-1:0];
                n_res_state = w_rd_data[IW +: SW];
                n_res_end   = 1'b0;
                n_state     = S_EMIT;
            end
            S_SEARCH: begin
                if (r_lo < r_hi) begin
                    n_mid     = w_sum[CW:1];
                    w_rd_en   = 1'b1;
                    w_rd_addr = w_sum[AW:1];
                    n_state   = S_CMP;
                end else begin
                    n_cursor = r_lo;
                    n_state  = S_FETCH;
                end
            end
            S_CMP: begin
                // ids descend: narrow toward the first entry not above the target
                if (w_rd_data[IW-1:0] <= r_target) begin
                    n_hi = r_mid;
                end else begin
                    n_lo = r_mid + CW'(1);
                end
                n_state = S_SEARCH;
            end
            S_EMIT: begin
                if (!r_m_tvalid || m_axis_tready) begin
                    n_m_tvalid = 1'b1;
                    n_m_tdata  = dplc_pkg::OUT_DATA_W'({r_status, r_res_end,
                                                        r_res_state, r_res_id});
                    n_state    = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_count    <= '0;
            r_cursor   <= '0;
            r_m_tvalid <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_count    <= n_count;
            r_cursor   <= n_cursor;
            r_m_tvalid <= n_m_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_lo        <= n_lo;
        r_hi        <= n_hi;
        r_mid       <= n_mid;
        r_target    <= n_target;
        r_last_id   <= n_last_id;
        r_status    <= n_status;
        r_res_id    <= n_res_id;
        r_res_state <= n_res_state;
        r_res_end   <= n_res_end;
        r_m_tdata   <= n_m_tdata;
    end

endmodule

@@ sim/tb_top.sv @@
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_ENTRIES = 1024;
    localparam int STALL_LIMIT = 5000;
    localparam int DRAIN_CYCLES = 40;
    localparam int ID_W = dplc_pkg::ID_W;
    localparam int STATE_W = dplc_pkg::STATE_W;
    localparam int OP_W = dplc_pkg::OP_W;
    localparam int STAT_W = dplc_pkg::STAT_W;
    localparam int IN_DATA_W = dplc_pkg::IN_DATA_W;
    localparam int OUT_DATA_W = dplc_pkg::OUT_DATA_W;
    localparam logic [ID_W-1:0] ALL_ONES = '1;
    localparam logic [ID_W-1:0] TOP_BIT = 64'h8000_0000_0000_0000;

    typedef struct {
        logic [ID_W-1:0]    id;
        logic [STATE_W-1:0] state;
        logic               at_end;
        dplc_pkg::t_status  status;
    } t_cursor_view;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_axis_tdata;

    // shadow copy of the list and the cursor
    logic [ID_W-1:0]    shadow_ids [MAX_ENTRIES];
    logic [STATE_W-1:0] shadow_states [MAX_ENTRIES];
    int                 shadow_count = 0;
    int                 shadow_cursor = 0;

    t_cursor_view expected_views [$];
    int           err_count = 0;
    bit           idle_en = 1'b1;
    int           rx_hold = 0;

    descending_posting_list_cursor #(
        .MAX_ENTRIES(MAX_ENTRIES)
    ) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic logic [ID_W-1:0] rand64();
        return {$urandom, $urandom};
    endfunction

    function automatic logic [STATE_W-1:0] rand8();
        return STATE_W'($urandom);
    endfunction

    // Apply one operation to the shadow list and return the cursor view after it.
    function automatic t_cursor_view apply_to_shadow(input dplc_pkg::t_opcode op,
                                                     input logic [ID_W-1:0] id,
                                                     input logic [STATE_W-1:0] st);
        t_cursor_view v;
        int k;
        v.status = dplc_pkg::ST_OK;
        case (op)
            dplc_pkg::OP_CLEAR: begin
                shadow_count = 0;
                shadow_cursor = 0;
            end
            dplc_pkg::OP_APPEND: begin
                if (shadow_count >= MAX_ENTRIES) begin
                    v.status = dplc_pkg::ST_FULL;
                end else if (shadow_count > 0 && id >= shadow_ids[shadow_count-1]) begin
                    v.status = dplc_pkg::ST_ORDER;
                end else begin
                    shadow_ids[shadow_count] = id;
                    shadow_states[shadow_count] = st;
                    shadow_count++;
                end
            end
            dplc_pkg::OP_STEP: begin
                if (shadow_cursor < shadow_count) shadow_cursor++;
            end
            default: begin
                // ids are strictly descending: first one not above the target
                k = 0;
                while (k < shadow_count && shadow_ids[k] > id) k++;
                shadow_cursor = k;
            end
        endcase
        if (shadow_cursor < shadow_count) begin
            v.id = shadow_ids[shadow_cursor];
            v.state = shadow_states[shadow_cursor];
            v.at_end = 1'b0;
        end else begin
            v.id = '0;
            v.state = '0;
            v.at_end = 1'b1;
        end
        return v;
    endfunction

    // Called at a falling edge; returns at the falling edge after the transfer.
    task automatic send_item(input dplc_pkg::t_opcode op, input logic [ID_W-1:0] id,
                             input logic [STATE_W-1:0] st);
        logic [IN_DATA_W-1:0] word;
        word = '0;
        word[OP_W-1:0] = op;
        word[OP_W +: ID_W] = id;
        word[OP_W+ID_W +: STATE_W] = st;
        if (idle_en && $urandom_range(0, 3) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= word;
        expected_views.push_back(apply_to_shadow(op, id, st));
        do @(posedge i_clk); while (!s_axis_tready);
        @(negedge i_clk);
    endtask

    function automatic logic [ID_W-1:0] next_below(input logic [ID_W-1:0] prev,
                                                   input int shift);
        logic [ID_W-1:0] gap;
        gap = rand64() >> shift;
        if (prev > gap) return prev - 1 - gap;
        else if (prev != 0) return prev - 1;
        else return '0;
    endfunction

    // Aim skips mostly at stored ids and their neighbors.
    function automatic logic [ID_W-1:0] pick_target();
        int r;
        int idx;
        r = $urandom_range(0, 9);
        if (r < 5 && shadow_count > 0) begin
            idx = $urandom_range(0, shadow_count - 1);
            case ($urandom_range(0, 2))
                0: return shadow_ids[idx] - 1;
                1: return shadow_ids[idx];
                default: return shadow_ids[idx] + 1;
            endcase
        end else if (r == 5) begin
            return '0;
        end else if (r == 6) begin
            return ALL_ONES;
        end
        return rand64();
    endfunction

    task automatic send_cursor_move();
        if ($urandom_range(0, 2) == 0) send_item(dplc_pkg::OP_STEP, rand64(), rand8());
        else send_item(dplc_pkg::OP_SKIP, pick_target(), rand8());
    endtask

    task automatic send_random_op();
        int r;
        logic [ID_W-1:0] last_id;
        r = $urandom_range(0, 99);
        last_id = (shadow_count > 0) ? shadow_ids[shadow_count-1] : ALL_ONES;
        if (r < 50) begin
            if (shadow_count == 0) begin
                send_item(dplc_pkg::OP_APPEND, rand64(), rand8());
            end else begin
                send_item(dplc_pkg::OP_APPEND, next_below(last_id, $urandom_range(8, 63)),
                          rand8());
            end
        end else if (r < 60) begin
            // out of order: equal to, just above, or anywhere
            if (shadow_count > 0 && $urandom_range(0, 1) == 0)
                send_item(dplc_pkg::OP_APPEND, last_id + ID_W'($urandom_range(0, 3)), rand8());
            else
                send_item(dplc_pkg::OP_APPEND, rand64(), rand8());
        end else if (r < 97) begin
            send_cursor_move();
        end else begin
            send_item(dplc_pkg::OP_CLEAR, rand64(), rand8());
        end
    endtask

    task automatic test_empty_list();
        send_item(dplc_pkg::OP_STEP, '0, '0);
        send_item(dplc_pkg::OP_SKIP, '0, '0);
        send_item(dplc_pkg::OP_SKIP, ALL_ONES, 8'hff);
        send_item(dplc_pkg::OP_CLEAR, ALL_ONES, 8'hff);
    endtask

    task automatic test_directed_edges();
        send_item(dplc_pkg::OP_APPEND, ALL_ONES, 8'hff);
        send_item(dplc_pkg::OP_APPEND, ALL_ONES, 8'h00);
        send_item(dplc_pkg::OP_APPEND, 64'h8000_0000_0000_0000, 8'h5a);
        send_item(dplc_pkg::OP_APPEND, 64'h8000_0000_0000_0000, 8'ha5);
        send_item(dplc_pkg::OP_APPEND, 64'd1, 8'h01);
        send_item(dplc_pkg::OP_APPEND, 64'd0, 8'h00);
        send_item(dplc_pkg::OP_APPEND, 64'd0, 8'hff);
        send_item(dplc_pkg::OP_SKIP, ALL_ONES, '0);
        send_item(dplc_pkg::OP_SKIP, '0, '0);
        send_item(dplc_pkg::OP_SKIP, 64'h7fff_ffff_ffff_ffff, '0);
        send_item(dplc_pkg::OP_SKIP, 64'h8000_0000_0000_0000, '0);
        send_item(dplc_pkg::OP_STEP, '0, '0);
        send_item(dplc_pkg::OP_STEP, '0, '0);
        send_item(dplc_pkg::OP_STEP, '0, '0);
        send_item(dplc_pkg::OP_STEP, ALL_ONES, 8'hff);
        send_item(dplc_pkg::OP_APPEND, ALL_ONES, 8'h77);
        send_item(dplc_pkg::OP_CLEAR, '0, '0);
        send_item(dplc_pkg::OP_APPEND, 64'd5, 8'h33);
        send_item(dplc_pkg::OP_SKIP, 64'd4, '0);
        // cursor sits at the end, so it lands on the new entry
        send_item(dplc_pkg::OP_APPEND, 64'd3, 8'hcc);
        send_item(dplc_pkg::OP_SKIP, 64'd4, '0);
        send_item(dplc_pkg::OP_CLEAR, '0, '0);
    endtask

    task automatic test_full_list();
        send_item(dplc_pkg::OP_CLEAR, rand64(), rand8());
        send_item(dplc_pkg::OP_APPEND, rand64() | TOP_BIT, rand8());
        while (shadow_count < MAX_ENTRIES) begin
            if ($urandom_range(0, 15) == 0) send_cursor_move();
            send_item(dplc_pkg::OP_APPEND,
                      next_below(shadow_ids[shadow_count-1], $urandom_range(40, 63)),
                      rand8());
        end
        // full wins over a well-ordered id and over a bad one
        send_item(dplc_pkg::OP_APPEND, shadow_ids[MAX_ENTRIES-1] - 1, rand8());
        send_item(dplc_pkg::OP_APPEND, ALL_ONES, rand8());
        send_item(dplc_pkg::OP_SKIP, ALL_ONES, '0);
        send_item(dplc_pkg::OP_SKIP, '0, '0);
        repeat (40) send_cursor_move();
        send_item(dplc_pkg::OP_CLEAR, rand64(), rand8());
    endtask

    task automatic test_random_lists();
        repeat (420) send_random_op();
    endtask

    task automatic test_output_stall();
        rx_hold = 300;
        repeat (30) send_random_op();
    endtask

    task automatic test_no_idling();
        idle_en = 1'b0;
        repeat (120) send_random_op();
    endtask

    // receiver: random stall bursts, plus long hold-off on request
    initial begin
        int burst;
        burst = 0;
        forever begin
            @(negedge i_clk);
            if (rx_hold > 0) begin
                m_axis_tready <= 1'b0;
                rx_hold--;
            end else if (burst > 0) begin
                m_axis_tready <= 1'b0;
                burst--;
            end else if (idle_en && $urandom_range(0, 7) == 0) begin
                m_axis_tready <= 1'b0;
                burst = $urandom_range(1, 8) - 1;
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        t_cursor_view exp_v;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (expected_views.size() == 0) begin
                $error("unexpected result transfer: %h", m_axis_tdata);
                err_count++;
            end else begin
                exp_v = expected_views.pop_front();
                if (m_axis_tdata[ID_W-1:0] !== exp_v.id) begin
                    $error("cur_id: expected %h, got %h", exp_v.id, m_axis_tdata[ID_W-1:0]);
                    err_count++;
                end
                if (m_axis_tdata[ID_W +: STATE_W] !== exp_v.state) begin
                    $error("cur_state: expected %h, got %h", exp_v.state,
                           m_axis_tdata[ID_W +: STATE_W]);
                    err_count++;
                end
                if (m_axis_tdata[ID_W+STATE_W] !== exp_v.at_end) begin
                    $error("at_end: expected %b, got %b", exp_v.at_end,
                           m_axis_tdata[ID_W+STATE_W]);
                    err_count++;
                end
                if (m_axis_tdata[ID_W+STATE_W+1 +: STAT_W] !== exp_v.status) begin
                    $error("status: expected %0d, got %0d", exp_v.status,
                           m_axis_tdata[ID_W+STATE_W+1 +: STAT_W]);
                    err_count++;
                end
            end
        end
    end

    // watchdog: end the run when no transfer happens for too long
    initial begin
        int stalled;
        stalled = 0;
        while (stalled < STALL_LIMIT) begin
            @(posedge i_clk);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                stalled = 0;
            else
                stalled++;
        end
        $display("tb: failure");
        $finish;
    end

    initial begin
        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        test_empty_list();
        test_directed_edges();
        test_full_list();
        test_random_lists();
        test_output_stall();
        test_no_idling();
        s_axis_tvalid <= 1'b0;
        while (expected_views.size() > 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (err_count == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
